FILE: rtl/mprd_pkg.sv
// ----------------------------------------------------------------------------
// mprd_pkg
// Types, constants and helper functions for the mouse packet router and
// decoder: packet phases, register indexes and the response record.
// ----------------------------------------------------------------------------
package mprd_pkg;

   // coordinate and byte widths
   localparam int POS_W  = 10;
   localparam int BYTE_W = 8;
   localparam int BTN_W  = 2;

   // header byte pattern 111110LR
   localparam logic [BYTE_W-1:0] HDR_MASK = 8'hFC;
   localparam logic [BYTE_W-1:0] HDR_MARK = 8'hF8;

   // clamp limits after reset
   localparam logic [POS_W-1:0] MAX_X_RST = 10'd319;
   localparam logic [POS_W-1:0] MAX_Y_RST = 10'd199;

   // register index codes of the csr port
   typedef enum logic {
      CSR_MAX_X = 1'b0,
      CSR_MAX_Y = 1'b1
   } csr_index_type;

   // position inside a three-byte mouse packet
   typedef enum logic [1:0] {
      PHASE_HEADER = 2'd0,
      PHASE_DX     = 2'd1,
      PHASE_DY     = 2'd2
   } phase_type;

   // one response transaction
   typedef struct packed {
      logic              key_valid;
      logic [BYTE_W-1:0] key_byte;
      logic              mouse_update;
      logic [POS_W-1:0]  cursor_x;
      logic [POS_W-1:0]  cursor_y;
      logic [BTN_W-1:0]  button_bits;
   } rsp_type;

   // add a signed byte delta to a position and clamp to 0..lim
   function automatic logic [POS_W-1:0] clamp_axis(
      input logic [POS_W-1:0]  pos,
      input logic [BYTE_W-1:0] delta,
      input logic [POS_W-1:0]  lim
   );
      logic [POS_W+1:0] sum;
      logic [POS_W-1:0] res;
      sum = {2'b00, pos} + {{(POS_W+2-BYTE_W){delta[BYTE_W-1]}}, delta};
      if (sum[POS_W+1]) begin
         res = '0;
      end else if (sum[POS_W:0] > {1'b0, lim}) begin
         res = lim;
      end else begin
         res = sum[POS_W-1:0];
      end
      return res;
   endfunction

endpackage

FILE: rtl/mouse_packet_router_decoder_core.sv
// ----------------------------------------------------------------------------
// mouse_packet_router_decoder_core
// Splits a received keyboard-link byte stream into keyboard bytes and
// three-byte relative mouse packets, keeping a clamped cursor position.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake               payload
//   req       in          req_valid / req_ready   req_rx_byte
//   rsp       out         rsp_valid / rsp_ready   rsp_key_valid .. rsp_button_bits
//   csr       in          csr_wr_en               csr_index, csr_wr_data
//
// One transaction per cycle while req_ready is high: the decode and clamp
// logic sits between the request port and the head or skid response register.
// A two-entry response buffer (head plus skid) keeps req_ready high while
// one response waits; req_ready drops only when both entries are full.
// Reset is synchronous and returns phase, position, buttons and limits
// to their defaults; csr writes are taken in every cycle.

module mouse_packet_router_decoder_core (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [mprd_pkg::BYTE_W-1:0]  req_rx_byte,

   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_key_valid,
   output logic [mprd_pkg::BYTE_W-1:0]  rsp_key_byte,
   output logic                         rsp_mouse_update,
   output logic [mprd_pkg::POS_W-1:0]   rsp_cursor_x,
   output logic [mprd_pkg::POS_W-1:0]   rsp_cursor_y,
   output logic [mprd_pkg::BTN_W-1:0]   rsp_button_bits,

   input  logic                         csr_wr_en,
   input  logic                         csr_index,
   input  logic [mprd_pkg::POS_W-1:0]   csr_wr_data
);

   // configuration registers
   logic [mprd_pkg::POS_W-1:0] max_x_ff;
   logic [mprd_pkg::POS_W-1:0] max_y_ff;

   // decoder state
   mprd_pkg::phase_type         phase_ff, phase_in;
   logic [mprd_pkg::BTN_W-1:0]  hdr_btn_ff, hdr_btn_in;
   logic [mprd_pkg::BYTE_W-1:0] dx_ff, dx_in;
   logic [mprd_pkg::POS_W-1:0]  pos_x_ff, pos_x_in;
   logic [mprd_pkg::POS_W-1:0]  pos_y_ff, pos_y_in;
   logic [mprd_pkg::BTN_W-1:0]  btn_ff, btn_in;

   // response buffer
   mprd_pkg::rsp_type head_ff, head_in;
   mprd_pkg::rsp_type skid_ff, skid_in;
   logic              head_vld_ff, head_vld_in;
   logic              skid_vld_ff, skid_vld_in;

   mprd_pkg::rsp_type rsp_new;
   logic              push;
   logic              pop;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_x_ff <= mprd_pkg::MAX_X_RST;
         max_y_ff <= mprd_pkg::MAX_Y_RST;
      end else if (csr_wr_en) begin
         case (mprd_pkg::csr_index_type'(csr_index))
            mprd_pkg::CSR_MAX_X: max_x_ff <= csr_wr_data;
            mprd_pkg::CSR_MAX_Y: max_y_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // handshakes
   assign req_ready = !skid_vld_ff;
   assign push      = req_valid && req_ready;
   assign rsp_valid = head_vld_ff;
   assign pop       = head_vld_ff && rsp_ready;

   // byte decode and cursor update
   always_comb begin
      phase_in   = phase_ff;
      hdr_btn_in = hdr_btn_ff;
      dx_in      = dx_ff;
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      btn_in     = btn_ff;
      rsp_new    = '0;
      case (phase_ff)
         mprd_pkg::PHASE_DX: begin
            dx_in    = req_rx_byte;
            phase_in = mprd_pkg::PHASE_DY;
         end
         mprd_pkg::PHASE_DY: begin
            btn_in   = hdr_btn_ff;
            pos_x_in = mprd_pkg::clamp_axis(pos_x_ff, dx_ff, max_x_ff);
            pos_y_in = mprd_pkg::clamp_axis(pos_y_ff, req_rx_byte, max_y_ff);
            phase_in = mprd_pkg::PHASE_HEADER;
            rsp_new.mouse_update = 1'b1;
         end
         default: begin
            // header or keyboard byte; the unused phase code lands here too
            phase_in = mprd_pkg::PHASE_HEADER;
            if ((req_rx_byte & mprd_pkg::HDR_MASK) == mprd_pkg::HDR_MARK) begin
               hdr_btn_in = req_rx_byte[mprd_pkg::BTN_W-1:0];
               phase_in   = mprd_pkg::PHASE_DX;
            end else begin
               rsp_new.key_valid = 1'b1;
               rsp_new.key_byte  = req_rx_byte;
            end
         end
      endcase
      rsp_new.cursor_x    = pos_x_in;
      rsp_new.cursor_y    = pos_y_in;
      rsp_new.button_bits = btn_in;
   end

   // decoder state registers, advanced on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= mprd_pkg::PHASE_HEADER;
         hdr_btn_ff <= '0;
         dx_ff      <= '0;
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         btn_ff     <= '0;
      end else if (push) begin
         phase_ff   <= phase_in;
         hdr_btn_ff <= hdr_btn_in;
         dx_ff      <= dx_in;
         pos_x_ff   <= pos_x_in;
         pos_y_ff   <= pos_y_in;
         btn_ff     <= btn_in;
      end
   end

   // head and skid entry update
   always_comb begin
      head_in     = head_ff;
      skid_in     = skid_ff;
      head_vld_in = head_vld_ff;
      skid_vld_in = skid_vld_ff;
      if (skid_vld_ff) begin
         // full: no push possible, drain the skid entry into the head
         if (pop) begin
            head_in     = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (head_vld_ff) begin
         if (push && pop) begin
            head_in = rsp_new;
         end else if (push) begin
            skid_in     = rsp_new;
            skid_vld_in = 1'b1;
         end else if (pop) begin
            head_vld_in = 1'b0;
         end
      end else if (push) begin
         head_in     = rsp_new;
         head_vld_in = 1'b1;
      end
   end

   // response buffer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         head_vld_ff <= head_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   // response ports
   assign rsp_key_valid    = head_ff.key_valid;
   assign rsp_key_byte     = head_ff.key_byte;
   assign rsp_mouse_update = head_ff.mouse_update;
   assign rsp_cursor_x     = head_ff.cursor_x;
   assign rsp_cursor_y     = head_ff.cursor_y;
   assign rsp_button_bits  = head_ff.button_bits;

   // skid entry is only ever filled behind a valid head
   a_skid_behind_head: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> head_vld_ff)
      else $error("skid entry valid while head entry empty");

   // a response is never both a keyboard byte and a mouse update
   a_kind_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_key_valid && rsp_mouse_update))
      else $error("response flagged as keyboard byte and mouse update");

   // an accepted header byte opens a packet
   a_header_opens: assert property (@(posedge clock) disable iff (reset)
      (push && phase_ff == mprd_pkg::PHASE_HEADER
       && (req_rx_byte & mprd_pkg::HDR_MASK) == mprd_pkg::HDR_MARK)
      |=> phase_ff == mprd_pkg::PHASE_DX)
      else $error("header byte did not start a mouse packet");

   // a drained head with a full skid shows the former skid entry next
   a_skid_forward: assert property (@(posedge clock) disable iff (reset)
      (skid_vld_ff && pop) |=> (head_vld_ff && head_ff == $past(skid_ff)))
      else $error("skid entry lost on drain");

endmodule
